>>> hw/rtl/project_point_to_pixel_macros.svh
// Assertion macros shared by the point-to-pixel RTL.
`ifndef PROJECT_POINT_TO_PIXEL_MACROS_SVH
`define PROJECT_POINT_TO_PIXEL_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define PTP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define PTP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/ptp_pkg.sv
// Types and constants of the point-to-pixel projection pipeline.
`default_nettype none
package ptp_pkg;

	localparam int NUM_REGS = 6;
	localparam int REG_W    = 64;
	localparam int COEF_W   = 32;
	localparam int PT_W     = 32;
	localparam int PROD_W   = 64;
	localparam int PSUM_W   = 65;
	localparam int SUM_W    = 66;
	localparam int MAG_W    = 64;
	localparam int QBITS    = 16;
	localparam int PIX_W    = 16;
	localparam int IDX_W    = 3;

	localparam logic [IDX_W-1:0] REG_R0_C01 = 3'd0;
	localparam logic [IDX_W-1:0] REG_R0_C23 = 3'd1;
	localparam logic [IDX_W-1:0] REG_R1_C01 = 3'd2;
	localparam logic [IDX_W-1:0] REG_R1_C23 = 3'd3;
	localparam logic [IDX_W-1:0] REG_R2_C01 = 3'd4;
	localparam logic [IDX_W-1:0] REG_R2_C23 = 3'd5;

	localparam logic signed [PIX_W-1:0] PIX_MAX = 16'sh7FFF;
	localparam logic signed [PIX_W-1:0] PIX_MIN = 16'sh8000;

	typedef logic [NUM_REGS-1:0][REG_W-1:0] cfg_arr_t;

	// Divider work word: remainders, shared divisor, quotient bits and flags.
	typedef struct packed {
		logic [MAG_W-1:0] rem_u;
		logic [MAG_W-1:0] rem_v;
		logic [MAG_W-1:0] den;
		logic [QBITS-1:0] quo_u;
		logic [QBITS-1:0] quo_v;
		logic             neg_u;
		logic             neg_v;
		logic             ovf_u;
		logic             ovf_v;
		logic             dzero;
	} div_t;

endpackage
`default_nettype wire

>>> hw/rtl/ptp_mac.sv
// Matrix-vector product: multiply, two add levels, then sign and magnitude.
`default_nettype none
module ptp_mac #(
	parameter int FRACTION_BITS = 16
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire ptp_pkg::cfg_arr_t                 cfg,
	input  wire logic                              up_valid,
	output logic                                   up_stall,
	input  wire logic signed [ptp_pkg::PT_W-1:0]   px,
	input  wire logic signed [ptp_pkg::PT_W-1:0]   py,
	input  wire logic signed [ptp_pkg::PT_W-1:0]   pz,
	output logic                                   dn_valid,
	input  wire logic                              dn_stall,
	output ptp_pkg::div_t                          dn_data
);
	import ptp_pkg::*;

	logic signed [PROD_W-1:0] prod_s1 [3][3];
	logic signed [PROD_W-1:0] cst_s1  [3];
	logic signed [PSUM_W-1:0] pa_s2   [3];
	logic signed [PSUM_W-1:0] pb_s2   [3];
	logic signed [SUM_W-1:0]  sum_s3  [3];
	logic v_s1, v_s2, v_s3, v_s4;
	logic h1, h2, h3, h4;
	div_t d_s4;

	logic signed [PROD_W-1:0] prod_c [3][3];
	logic signed [PROD_W-1:0] cst_c  [3];
	logic [MAG_W-1:0]         mag_c  [3];
	logic                     sgn_c  [3];

	// A stage holds when it is full and the one after it holds.
	assign h4 = v_s4 && dn_stall;
	assign h3 = v_s3 && h4;
	assign h2 = v_s2 && h3;
	assign h1 = v_s1 && h2;
	assign up_stall = h1;
	assign dn_valid = v_s4;
	assign dn_data  = d_s4;

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			prod_c[r][0] = px * $signed(cfg[2*r][COEF_W-1:0]);
			prod_c[r][1] = py * $signed(cfg[2*r][REG_W-1:COEF_W]);
			prod_c[r][2] = pz * $signed(cfg[2*r+1][COEF_W-1:0]);
			// constant column is scaled by 1.0
			cst_c[r] = PROD_W'($signed(cfg[2*r+1][REG_W-1:COEF_W])) <<< FRACTION_BITS;
		end
	end

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			sgn_c[r] = sum_s3[r][SUM_W-1];
			mag_c[r] = sgn_c[r] ? MAG_W'(-sum_s3[r]) : sum_s3[r][MAG_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (!h1) v_s1 <= up_valid;
			if (!h2) v_s2 <= v_s1;
			if (!h3) v_s3 <= v_s2;
			if (!h4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (!h1) begin
			prod_s1 <= prod_c;
			cst_s1  <= cst_c;
		end
		if (!h2) begin
			for (int r = 0; r < 3; r++) begin
				pa_s2[r] <= PSUM_W'(prod_s1[r][0]) + PSUM_W'(prod_s1[r][1]);
				pb_s2[r] <= PSUM_W'(prod_s1[r][2]) + PSUM_W'(cst_s1[r]);
			end
		end
		if (!h3) begin
			for (int r = 0; r < 3; r++)
				sum_s3[r] <= SUM_W'(pa_s2[r]) + SUM_W'(pb_s2[r]);
		end
		if (!h4) begin
			d_s4.rem_u <= mag_c[0];
			d_s4.rem_v <= mag_c[1];
			d_s4.den   <= mag_c[2];
			d_s4.quo_u <= '0;
			d_s4.quo_v <= '0;
			d_s4.neg_u <= sgn_c[0] ^ sgn_c[2];
			d_s4.neg_v <= sgn_c[1] ^ sgn_c[2];
			d_s4.ovf_u <= 1'b0;
			d_s4.ovf_v <= 1'b0;
			d_s4.dzero <= (mag_c[2] == '0);
		end
	end

endmodule
`default_nettype wire

>>> hw/rtl/ptp_div_step.sv
// One restoring-division stage for both pixel quotients; top stage checks overflow.
`default_nettype none
module ptp_div_step #(
	parameter int BIT = 0
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           up_valid,
	output logic                up_stall,
	input  wire ptp_pkg::div_t  up_data,
	output logic                dn_valid,
	input  wire logic           dn_stall,
	output ptp_pkg::div_t       dn_data
);
	import ptp_pkg::*;

	localparam bit               IS_OVF   = (BIT == QBITS);
	localparam logic [3:0]       QIDX     = 4'(BIT % QBITS);
	localparam logic [MAG_W-1:0] LOW_MASK = (MAG_W'(1) << BIT) - MAG_W'(1);

	logic             v_s1;
	div_t             d_s1;
	div_t             nxt;
	logic             hold;
	logic [MAG_W:0]   diff_u, diff_v;
	logic             ge_u, ge_v;

	assign hold     = v_s1 && dn_stall;
	assign up_stall = hold;
	assign dn_valid = v_s1;
	assign dn_data  = d_s1;

	// rem >= den << BIT  is  (rem >> BIT) >= den
	assign diff_u = {1'b0, up_data.rem_u >> BIT} - {1'b0, up_data.den};
	assign diff_v = {1'b0, up_data.rem_v >> BIT} - {1'b0, up_data.den};
	assign ge_u   = !diff_u[MAG_W];
	assign ge_v   = !diff_v[MAG_W];

	always_comb begin
		nxt = up_data;
		if (IS_OVF) begin
			nxt.ovf_u = ge_u;
			nxt.ovf_v = ge_v;
		end else begin
			nxt.quo_u[QIDX] = ge_u;
			nxt.quo_v[QIDX] = ge_v;
			if (ge_u)
				nxt.rem_u = (diff_u[MAG_W-1:0] << BIT) | (up_data.rem_u & LOW_MASK);
			if (ge_v)
				nxt.rem_v = (diff_v[MAG_W-1:0] << BIT) | (up_data.rem_v & LOW_MASK);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (!hold) begin
			v_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!hold) d_s1 <= nxt;
	end

endmodule
`default_nettype wire

>>> hw/rtl/ptp_sat.sv
// Output stage: apply sign, saturate to 16 bits, force zero on zero depth.
`default_nettype none
`include "project_point_to_pixel_macros.svh"
module ptp_sat (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               up_valid,
	output logic                                    up_stall,
	input  wire ptp_pkg::div_t                      up_data,
	output logic                                    pixel_valid,
	input  wire logic                               pixel_stall,
	output logic signed [ptp_pkg::PIX_W-1:0]        pixel_u,
	output logic signed [ptp_pkg::PIX_W-1:0]        pixel_v,
	output logic                                    depth_zero,
	output logic                                    clipped
);
	import ptp_pkg::*;

	logic                    v_s1;
	logic signed [PIX_W-1:0] u_s1, v_pix_s1;
	logic                    dz_s1, clip_s1;
	logic                    hold;
	logic signed [PIX_W-1:0] u_c, v_c;
	logic                    cu_c, cv_c;

	function automatic logic [PIX_W:0] sat_one(input logic [QBITS-1:0] q,
			input logic neg, input logic ovf);
		logic [PIX_W:0] r;
		if (!neg) begin
			if (ovf || q[QBITS-1]) r = {1'b1, PIX_MAX};
			else                   r = {1'b0, PIX_W'(q)};
		end else begin
			if (ovf || (q > {1'b1, {(QBITS-1){1'b0}}})) r = {1'b1, PIX_MIN};
			else                                         r = {1'b0, PIX_W'(-q)};
		end
		return r;
	endfunction

	always_comb begin
		{cu_c, u_c} = sat_one(up_data.quo_u, up_data.neg_u, up_data.ovf_u);
		{cv_c, v_c} = sat_one(up_data.quo_v, up_data.neg_v, up_data.ovf_v);
	end

	assign hold        = v_s1 && pixel_stall;
	assign up_stall    = hold;
	assign pixel_valid = v_s1;
	assign pixel_u     = u_s1;
	assign pixel_v     = v_pix_s1;
	assign depth_zero  = dz_s1;
	assign clipped     = clip_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (!hold) begin
			v_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!hold) begin
			dz_s1 <= up_data.dzero;
			if (up_data.dzero) begin
				u_s1     <= '0;
				v_pix_s1 <= '0;
				clip_s1  <= 1'b0;
			end else begin
				u_s1     <= u_c;
				v_pix_s1 <= v_c;
				clip_s1  <= cu_c || cv_c;
			end
		end
	end

	`PTP_ASSERT_NOW(a_zero_depth, pixel_valid && depth_zero,
		pixel_u == '0 && pixel_v == '0 && !clipped, "zero depth item has nonzero pixels")
	`PTP_ASSERT_NOW(a_clip_rail, pixel_valid && clipped,
		pixel_u == PIX_MAX || pixel_u == PIX_MIN || pixel_v == PIX_MAX || pixel_v == PIX_MIN,
		"clipped item has no pixel on a rail")
	`PTP_ASSERT_NEXT(a_load, up_valid && !up_stall, pixel_valid,
		"item taken into output stage was lost")

endmodule
`default_nettype wire

>>> hw/rtl/project_point_to_pixel.sv
// Pipeline from point acceptance to pixel_valid: 4 product/sum stages,
// 17 compare-subtract divider stages, 1 saturation/output stage.
// Throughput: one point per cycle unless the pipeline is full and the output is stalled;
// each stage holds only when full and blocked below, so bubbles are squeezed out while the output is stalled.
// Reset (arst_n low): all stage valid bits and the six matrix registers clear to zero.
`default_nettype none
`include "project_point_to_pixel_macros.svh"
module project_point_to_pixel #(
	parameter int FRACTION_BITS = 16
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               psel,
	input  wire logic                               penable,
	input  wire logic                               pwrite,
	input  wire logic [5:0]                         paddr,
	input  wire logic [ptp_pkg::REG_W-1:0]          pwdata,
	output logic [ptp_pkg::REG_W-1:0]               prdata,
	output logic                                    pready,
	input  wire logic                               point_valid,
	output logic                                    point_stall,
	input  wire logic signed [ptp_pkg::PT_W-1:0]    point_x,
	input  wire logic signed [ptp_pkg::PT_W-1:0]    point_y,
	input  wire logic signed [ptp_pkg::PT_W-1:0]    point_z,
	output logic                                    pixel_valid,
	input  wire logic                               pixel_stall,
	output logic signed [ptp_pkg::PIX_W-1:0]        pixel_u,
	output logic signed [ptp_pkg::PIX_W-1:0]        pixel_v,
	output logic                                    depth_zero,
	output logic                                    clipped
);
	import ptp_pkg::*;

	localparam int NSTEP = QBITS + 1;

	cfg_arr_t         cfg_q;
	logic [IDX_W-1:0] widx;
	logic             cfg_wr;

	div_t dchain [NSTEP+1];
	logic vchain [NSTEP+1];
	logic schain [NSTEP+1];

	assign pready = 1'b1;
	assign widx   = paddr[5:3];
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wr && (widx < IDX_W'(NUM_REGS))) begin
			cfg_q[widx] <= pwdata;
		end
	end

	always_comb begin
		case (widx)
			REG_R0_C01: prdata = cfg_q[REG_R0_C01];
			REG_R0_C23: prdata = cfg_q[REG_R0_C23];
			REG_R1_C01: prdata = cfg_q[REG_R1_C01];
			REG_R1_C23: prdata = cfg_q[REG_R1_C23];
			REG_R2_C01: prdata = cfg_q[REG_R2_C01];
			REG_R2_C23: prdata = cfg_q[REG_R2_C23];
			default:    prdata = '0;
		endcase
	end

	ptp_mac #(
		.FRACTION_BITS(FRACTION_BITS)
	) u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.up_valid (point_valid),
		.up_stall (point_stall),
		.px       (point_x),
		.py       (point_y),
		.pz       (point_z),
		.dn_valid (vchain[0]),
		.dn_stall (schain[0]),
		.dn_data  (dchain[0])
	);

	// First stage checks quotient overflow, then one quotient bit per stage, MSB first.
	for (genvar g = 0; g < NSTEP; g++) begin : g_div
		ptp_div_step #(
			.BIT(QBITS - g)
		) u_step (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (vchain[g]),
			.up_stall (schain[g]),
			.up_data  (dchain[g]),
			.dn_valid (vchain[g+1]),
			.dn_stall (schain[g+1]),
			.dn_data  (dchain[g+1])
		);
	end

	ptp_sat u_sat (
		.clk         (clk),
		.arst_n      (arst_n),
		.up_valid    (vchain[NSTEP]),
		.up_stall    (schain[NSTEP]),
		.up_data     (dchain[NSTEP]),
		.pixel_valid (pixel_valid),
		.pixel_stall (pixel_stall),
		.pixel_u     (pixel_u),
		.pixel_v     (pixel_v),
		.depth_zero  (depth_zero),
		.clipped     (clipped)
	);

	`PTP_ASSERT_NEXT(a_cfg_write, cfg_wr && widx == REG_R0_C01,
		cfg_q[REG_R0_C01] == $past(pwdata), "matrix register write not taken")
	`PTP_ASSERT_NEXT(a_cfg_bad_idx, cfg_wr && widx >= IDX_W'(NUM_REGS),
		$stable(cfg_q), "write beyond register list changed the matrix")
	`PTP_ASSERT_NOW(a_stall_full, point_stall, pixel_valid && pixel_stall,
		"input stalled while output is not blocked")

endmodule
`default_nettype wire
